>>> rtl/cdq_pkg.sv
// package for the coordinate deque with search
// constants, command and status codes, result type; no dependencies
package cdq_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int COORD_BITS_DEF = 10;
  localparam int COST_BITS_DEF  = 8;

  localparam int MODE_W   = 4;
  localparam int FIELD_W  = 10;
  localparam int WCOST_W  = 8;
  localparam int CUT_W    = 8;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;
  localparam int CNT_W    = 9;
  localparam int SUM_W    = 16;

  localparam logic [MODE_W-1:0] CMD_PUSH_TAIL = 4'd0;
  localparam logic [MODE_W-1:0] CMD_PUSH_HEAD = 4'd1;
  localparam logic [MODE_W-1:0] CMD_POP_HEAD  = 4'd2;
  localparam logic [MODE_W-1:0] CMD_POP_TAIL  = 4'd3;
  localparam logic [MODE_W-1:0] CMD_CONTAINS  = 4'd4;
  localparam logic [MODE_W-1:0] CMD_REMOVE    = 4'd5;
  localparam logic [MODE_W-1:0] CMD_COST_SUM  = 4'd6;
  localparam logic [MODE_W-1:0] CMD_OVERLAP   = 4'd7;
  localparam logic [MODE_W-1:0] CMD_TRUNCATE  = 4'd8;
  localparam logic [MODE_W-1:0] CMD_CLEAR     = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  // one result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [FIELD_W-1:0]  out_y;
    logic [FIELD_W-1:0]  out_x;
    logic [WCOST_W-1:0]  out_cost;
    logic [POS_W-1:0]    match_position;
    logic [CNT_W-1:0]    removed_count;
    logic [SUM_W-1:0]    cost_total;
    logic [CNT_W-1:0]    occupancy;
  } result_t;

endpackage

>>> rtl/cdq_if.sv
// valid/ready channel interfaces for command and result transfers
// depends on cdq_pkg
interface cdq_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [cdq_pkg::MODE_W-1:0]  mode;
  logic [cdq_pkg::FIELD_W-1:0] pos_y;
  logic [cdq_pkg::FIELD_W-1:0] pos_x;
  logic [cdq_pkg::WCOST_W-1:0] entry_cost;
  logic [cdq_pkg::CUT_W-1:0]   cut_position;
  modport source (output valid, mode, pos_y, pos_x, entry_cost, cut_position, input ready);
  modport sink (input valid, mode, pos_y, pos_x, entry_cost, cut_position, output ready);
endinterface

interface cdq_res_if;
  logic                        valid;
  logic                        ready;
  logic [cdq_pkg::STATUS_W-1:0] status;
  logic                        found;
  logic [cdq_pkg::FIELD_W-1:0] out_y;
  logic [cdq_pkg::FIELD_W-1:0] out_x;
  logic [cdq_pkg::WCOST_W-1:0] out_cost;
  logic [cdq_pkg::POS_W-1:0]   match_position;
  logic [cdq_pkg::CNT_W-1:0]   removed_count;
  logic [cdq_pkg::SUM_W-1:0]   cost_total;
  logic [cdq_pkg::CNT_W-1:0]   occupancy;
  modport source (output valid, status, found, out_y, out_x, out_cost, match_position,
                  removed_count, cost_total, occupancy, input ready);
  modport sink (input valid, status, found, out_y, out_x, out_cost, match_position,
                removed_count, cost_total, occupancy, output ready);
endinterface

>>> rtl/coordinate_deque_with_search_top.sv
// top level of the coordinate deque with search
// depends on cdq_pkg, cdq_if, cdq_ctrl, cdq_datapath, cdq_ram
// One command at a time. Push, truncate, clear and unknown codes raise result valid from the
// decode state; pops read a single entry; contains, remove, cost sum and overlap walk
// every stored entry through the single read port of the entry memory, one entry a
// cycle. Walks and pops then pass the drain and finish states before the result. Results
// hold until the result transfer; the next command is taken the cycle after.
module coordinate_deque_with_search_top #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int COORD_BITS = cdq_pkg::COORD_BITS_DEF,
  parameter int COST_BITS  = cdq_pkg::COST_BITS_DEF
) (
  input logic clk,
  input logic rst,
  cdq_cmd_if.sink   cmd,
  cdq_res_if.source res
);

  logic needs_walk, walk_done;
  logic load, exec, walk_start, walk_step, walk_end;
  cdq_pkg::result_t result;

  cdq_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(cmd.valid), .in_ready(cmd.ready),
    .out_valid(res.valid), .out_ready(res.ready),
    .needs_walk(needs_walk), .walk_done(walk_done),
    .load(load), .exec(exec), .walk_start(walk_start),
    .walk_step(walk_step), .walk_end(walk_end)
  );

  cdq_datapath #(.DEPTH(DEPTH), .COORD_BITS(COORD_BITS), .COST_BITS(COST_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .mode(cmd.mode),
    .pos_y(COORD_BITS'(cmd.pos_y)),
    .pos_x(COORD_BITS'(cmd.pos_x)),
    .entry_cost(COST_BITS'(cmd.entry_cost)),
    .cut_position(cmd.cut_position),
    .load(load), .exec(exec), .walk_start(walk_start), .walk_step(walk_step),
    .walk_end(walk_end), .walk_done(walk_done), .needs_walk(needs_walk),
    .result(result)
  );

  assign res.status         = result.status;
  assign res.found          = result.found;
  assign res.out_y          = result.out_y;
  assign res.out_x          = result.out_x;
  assign res.out_cost       = result.out_cost;
  assign res.match_position = result.match_position;
  assign res.removed_count  = result.removed_count;
  assign res.cost_total     = result.cost_total;
  assign res.occupancy      = result.occupancy;

endmodule

>>> rtl/cdq_ram.sv
// generic single-port-write, single-read ram with registered read data
// no dependencies
module cdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/cdq_datapath.sv
// datapath: entry memory, head and count registers, walk pointers, accumulators
// depends on cdq_pkg and cdq_ram
module cdq_datapath #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int COORD_BITS = cdq_pkg::COORD_BITS_DEF,
  parameter int COST_BITS  = cdq_pkg::COST_BITS_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cdq_pkg::MODE_W-1:0]  mode,
  input  logic [COORD_BITS-1:0]       pos_y,
  input  logic [COORD_BITS-1:0]       pos_x,
  input  logic [COST_BITS-1:0]        entry_cost,
  input  logic [cdq_pkg::CUT_W-1:0]   cut_position,
  input  logic                        load,     // capture command
  input  logic                        exec,     // single-step commands
  input  logic                        walk_start,
  input  logic                        walk_step, // read data of index rd_i valid
  input  logic                        walk_end,
  output logic                        walk_done, // issued index reached count, or a pop command
  output logic                        needs_walk,
  output cdq_pkg::result_t            result
);

  localparam int EW = 2 * COORD_BITS + COST_BITS;

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [cdq_pkg::MODE_W-1:0]  cmd;
  logic [COORD_BITS-1:0]       ky, kx;
  logic [COST_BITS-1:0]        kc;
  logic [cdq_pkg::CUT_W-1:0]   kcut;

  // walk state
  logic [CW-1:0] iss;   // next index to read
  logic [CW-1:0] rd_i;  // index of data now on rdata
  logic [CW-1:0] keep;  // write pointer for remove
  logic [2*COORD_BITS-1:0] hkey;
  logic          hit;
  logic [CW-1:0] hit_pos;
  logic [cdq_pkg::SUM_W:0] sum;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = {1'b0, h} + {1'b0, p};
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  cdq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [COORD_BITS-1:0] ry, rx;
  logic [COST_BITS-1:0]  rc;
  assign {ry, rx, rc} = rdata;
  logic match_key;
  assign match_key = (ry == ky) && (rx == kx);

  // running cost sum plus the entry now on the read port
  logic [cdq_pkg::SUM_W:0] sum_add;
  assign sum_add = sum + (cdq_pkg::SUM_W+1)'(rc);

  assign needs_walk = (cmd == cdq_pkg::CMD_CONTAINS) || (cmd == cdq_pkg::CMD_REMOVE) ||
                      (cmd == cdq_pkg::CMD_COST_SUM) || (cmd == cdq_pkg::CMD_OVERLAP) ||
                      (cmd == cdq_pkg::CMD_POP_HEAD) || (cmd == cdq_pkg::CMD_POP_TAIL);
  assign walk_done  = (iss >= count) || (cmd == cdq_pkg::CMD_POP_HEAD) ||
                      (cmd == cdq_pkg::CMD_POP_TAIL);

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = head;
    wdata = {ky, kx, kc};
    raddr = slot(head, iss);
    if (cmd == cdq_pkg::CMD_POP_HEAD) begin
      raddr = head;
    end else if (cmd == cdq_pkg::CMD_POP_TAIL) begin
      raddr = slot(head, count - CW'(1));
    end
    if (exec && ((cmd == cdq_pkg::CMD_PUSH_TAIL) || (cmd == cdq_pkg::CMD_PUSH_HEAD)) &&
        (count < CW'(DEPTH))) begin
      we = 1'b1;
      if ((cmd == cdq_pkg::CMD_PUSH_HEAD) && (count != '0)) begin
        waddr = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
      end else begin
        waddr = slot(head, count);
      end
    end else if (walk_step && (cmd == cdq_pkg::CMD_REMOVE) && !match_key && (keep != rd_i)) begin
      we    = 1'b1;
      waddr = slot(head, keep);
      wdata = rdata;
    end
  end

  function automatic logic [cdq_pkg::CNT_W-1:0] cnt9(input logic [CW-1:0] v);
    logic [CW+cdq_pkg::CNT_W-1:0] t;
    t = {{cdq_pkg::CNT_W{1'b0}}, v};
    return t[cdq_pkg::CNT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
      cmd <= cdq_pkg::CMD_CLEAR;
    end else begin
      if (load) begin
        cmd  <= mode;
        ky   <= pos_y;
        kx   <= pos_x;
        kc   <= entry_cost;
        kcut <= cut_position;
        result <= '0;
      end
      if (walk_start) begin
        iss <= '0;
        rd_i <= '0;
        keep <= '0;
        hit <= 1'b0;
        hit_pos <= '0;
        sum <= '0;
        if (cmd == cdq_pkg::CMD_OVERLAP || cmd == cdq_pkg::CMD_POP_HEAD ||
            cmd == cdq_pkg::CMD_POP_TAIL) begin
          if (count == '0) begin
            result.status <= cdq_pkg::ST_EMPTY;
          end
        end
      end else if (!walk_end && needs_walk && !walk_done) begin
        iss <= iss + CW'(1);
      end
      if (walk_step) begin
        rd_i <= rd_i + CW'(1);
        unique case (cmd)
          cdq_pkg::CMD_CONTAINS: begin
            if (match_key) begin
              hit <= 1'b1;
            end
          end
          cdq_pkg::CMD_REMOVE: begin
            if (!match_key) begin
              keep <= keep + CW'(1);
            end
          end
          cdq_pkg::CMD_COST_SUM: begin
            if (sum[cdq_pkg::SUM_W] || (sum_add > (cdq_pkg::SUM_W+1)'(17'hFFFF))) begin
              sum <= (cdq_pkg::SUM_W+1)'(17'h10000);
            end else begin
              sum <= sum_add;
            end
          end
          cdq_pkg::CMD_OVERLAP: begin
            if (rd_i == '0) begin
              hkey <= {ry, rx};
            end else if (!hit && ({ry, rx} == hkey)) begin
              hit <= 1'b1;
              hit_pos <= rd_i;
            end
          end
          default: begin
          end
        endcase
      end
      // commands without a walk, and finishing of walks
      if (exec) begin
        unique case (cmd) inside
          cdq_pkg::CMD_PUSH_TAIL, cdq_pkg::CMD_PUSH_HEAD: begin
            if (count >= CW'(DEPTH)) begin
              result.status <= cdq_pkg::ST_FULL;
              result.occupancy <= cnt9(count);
            end else begin
              if ((cmd == cdq_pkg::CMD_PUSH_HEAD) && (count != '0)) begin
                head <= waddr;
              end
              count <= count + CW'(1);
              result.occupancy <= cnt9(count + CW'(1));
            end
          end
          cdq_pkg::CMD_TRUNCATE: begin
            if ((kcut == '0) || ({{CW{1'b0}}, kcut} >= {{cdq_pkg::CUT_W{1'b0}}, count})) begin
              result.status <= cdq_pkg::ST_BADPOS;
              result.occupancy <= cnt9(count);
            end else begin
              result.removed_count <= cnt9(count - CW'(kcut));
              count <= CW'(kcut);
              result.occupancy <= cnt9(CW'(kcut));
            end
          end
          cdq_pkg::CMD_CLEAR: begin
            result.removed_count <= cnt9(count);
            count <= '0;
            head <= '0;
            result.occupancy <= '0;
          end
          default: begin
            result.occupancy <= cnt9(count);
          end
        endcase
      end
      if (walk_end) begin
        unique case (cmd) inside
          cdq_pkg::CMD_POP_HEAD, cdq_pkg::CMD_POP_TAIL: begin
            if (count != '0) begin
              result.out_y <= cdq_pkg::FIELD_W'(ry);
              result.out_x <= cdq_pkg::FIELD_W'(rx);
              result.out_cost <= cdq_pkg::WCOST_W'(rc);
              count <= count - CW'(1);
              result.occupancy <= cnt9(count - CW'(1));
              if (count == CW'(1)) begin
                head <= '0;
              end else if (cmd == cdq_pkg::CMD_POP_HEAD) begin
                head <= slot(head, CW'(1));
              end
            end else begin
              result.occupancy <= cnt9(count);
            end
          end
          cdq_pkg::CMD_CONTAINS: begin
            result.found <= hit;
            result.occupancy <= cnt9(count);
          end
          cdq_pkg::CMD_REMOVE: begin
            result.removed_count <= cnt9(count - keep);
            count <= keep;
            result.occupancy <= cnt9(keep);
            if (keep == '0) begin
              head <= '0;
            end
          end
          cdq_pkg::CMD_COST_SUM: begin
            result.cost_total <= sum[cdq_pkg::SUM_W] ? '1 : sum[cdq_pkg::SUM_W-1:0];
            result.occupancy <= cnt9(count);
          end
          cdq_pkg::CMD_OVERLAP: begin
            result.found <= hit;
            result.match_position <= hit_pos[cdq_pkg::POS_W-1:0];
            result.occupancy <= cnt9(count);
          end
          default: begin
            result.occupancy <= cnt9(count);
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/cdq_ctrl.sv
// controller: sequences command capture, memory walk and result transfer
// depends on cdq_pkg
module cdq_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic needs_walk,
  input  logic walk_done,
  output logic load,
  output logic exec,
  output logic walk_start,
  output logic walk_step,
  output logic walk_end
);

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_WALK, S_DRAIN, S_FINISH, S_OUT} state_t;
  state_t state;
  logic   pend; // a read was issued last cycle

  assign in_ready   = (state == S_IDLE);
  assign load       = in_valid && in_ready;
  assign exec       = (state == S_DECODE) && !needs_walk;
  assign walk_start = (state == S_DECODE) && needs_walk;
  assign walk_step  = pend && ((state == S_WALK) || (state == S_DRAIN));
  assign walk_end   = (state == S_FINISH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (load) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          pend <= 1'b0;
          if (needs_walk) begin
            state <= S_WALK;
          end else begin
            state <= S_OUT;
            out_valid <= 1'b1;
          end
        end
        S_WALK: begin
          // one read issued per cycle until every entry was addressed
          pend <= !walk_done;
          if (walk_done) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          pend <= 1'b0;
          state <= S_FINISH;
        end
        S_FINISH: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
